/* rtl/pwt_pkg.sv */
// Shared types and constants of the four-level page-table walker.
// Used by the channel interfaces, the controller and the datapath.
package pwt_pkg;

  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int WORD_W  = 64;
  localparam int WIDX_W  = 12;
  localparam int LIDX_W  = 9;

  localparam int HUGE_BIT    = 7;
  localparam int PRESENT_BIT = 0;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  typedef enum logic [1:0] {
    LVL_4,
    LVL_3,
    LVL_2,
    LVL_1
  } pwt_lvl_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_HUGE,
    OUT_PAGE
  } pwt_out_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic         wr;
    logic         rd;
    pwt_lvl_t     lvl;
    logic         load_va;
    logic         out_load;
    pwt_out_sel_t sel;
  } pwt_cmd_t;

  // datapath -> controller, decoded from the last entry read
  typedef struct packed {
    logic addr_zero;
    logic huge;
    logic present;
  } pwt_status_t;

endpackage

/* rtl/pwt_if.sv */
// Channel interfaces of the page-table walker: request, response, config.
// Depends on pwt_pkg for field widths.
interface pwt_req_if import pwt_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WIDX_W-1:0] word_index;
  logic [WORD_W-1:0] word_data;
  logic [VA_W-1:0]   virt_addr;

  modport source (output valid, kind, word_index, word_data, virt_addr, input ready);
  modport sink   (input valid, kind, word_index, word_data, virt_addr, output ready);
endinterface

interface pwt_rsp_if import pwt_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] xlat_addr;
  logic            mapped;
  logic            large_page;

  modport source (output valid, xlat_addr, mapped, large_page, input ready);
  modport sink   (input valid, xlat_addr, mapped, large_page, output ready);
endinterface

interface pwt_cfg_if import pwt_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/pwt_ctrl.sv */
// Walk sequencer: accepts items, steps through the four table levels and
// owns the response valid flag. Depends on pwt_pkg.
module pwt_ctrl import pwt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_ready,
  input  logic        out_ready,
  output logic        out_valid,
  input  pwt_status_t status,
  output pwt_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_L4,
    S_L3,
    S_L2,
    S_L1
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.lvl    = LVL_4;
    cmd.sel    = OUT_ZERO;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_WRITE) begin
            cmd.wr       = 1'b1;
            cmd.out_load = 1'b1;
          end else begin
            cmd.rd      = 1'b1;
            cmd.lvl     = LVL_4;
            cmd.load_va = 1'b1;
            state_next  = S_L4;
          end
        end
      end
      S_L4: begin
        if (status.addr_zero) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.rd     = 1'b1;
          cmd.lvl    = LVL_3;
          state_next = S_L3;
        end
      end
      S_L3: begin
        if (status.addr_zero) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.rd     = 1'b1;
          cmd.lvl    = LVL_2;
          state_next = S_L2;
        end
      end
      S_L2: begin
        if (status.huge || status.addr_zero) begin
          cmd.sel = status.huge ? OUT_HUGE : OUT_ZERO;
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.rd     = 1'b1;
          cmd.lvl    = LVL_1;
          state_next = S_L1;
        end
      end
      S_L1: begin
        cmd.sel = status.present ? OUT_PAGE : OUT_ZERO;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/pwt_dp.sv */
// Walker datapath: table store, root register, entry register, address
// formation and response registers. Depends on pwt_pkg.
module pwt_dp import pwt_pkg::*; #(
  parameter int STORE_WORDS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PA_W-1:0]   cfg_data,
  input  logic [WIDX_W-1:0] word_index,
  input  logic [WORD_W-1:0] word_data,
  input  logic [VA_W-1:0]   virt_addr,
  input  pwt_cmd_t          cmd,
  output pwt_status_t       status,
  output logic [PA_W-1:0]   xlat_addr,
  output logic              mapped,
  output logic              large_page
);

  // STORE_WORDS is a power of two; table addresses wrap on the low bits
  localparam int AW = $clog2(STORE_WORDS);

  logic [WORD_W-1:0] mem [STORE_WORDS];

  logic [PA_W-1:0]   root;
  logic [VA_W-1:0]   va;
  logic [WORD_W-1:0] entry;

  logic [PA_W-1:0]   base;
  logic [LIDX_W-1:0] lidx;
  logic [63:0]       rd_word;
  logic [15:0]       wr_word;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  always_comb begin
    case (cmd.lvl)
      LVL_4:   lidx = virt_addr[47:39];
      LVL_3:   lidx = va[38:30];
      LVL_2:   lidx = va[29:21];
      LVL_1:   lidx = va[20:12];
      default: lidx = '0;
    endcase
  end

  assign base = (cmd.lvl == LVL_4) ? root : entry[PA_W-1:0];

  // word = (base[51:12] << 9) + index; low 9 bits of the shifted base are zero
  assign rd_word = {15'b0, base[51:12], 9'b0} | {55'b0, lidx};
  assign rd_addr = rd_word[AW-1:0];
  assign wr_word = {4'b0, word_index};
  assign wr_addr = wr_word[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= word_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg_we) begin
      root <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_va) begin
      va <= virt_addr;
    end
  end

  assign status.addr_zero = (entry[51:12] == '0);
  assign status.huge      = entry[HUGE_BIT];
  assign status.present   = entry[PRESENT_BIT];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.sel)
        OUT_HUGE: begin
          xlat_addr  <= {entry[51:21], va[20:0]};
          mapped     <= 1'b1;
          large_page <= 1'b1;
        end
        OUT_PAGE: begin
          xlat_addr  <= {entry[51:12], va[11:0]};
          mapped     <= 1'b1;
          large_page <= 1'b0;
        end
        default: begin
          xlat_addr  <= '0;
          mapped     <= 1'b0;
          large_page <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/four_level_page_table_walker.sv */
// Channel   Dir  Fields                                     Transaction
// req       in   kind, word_index, word_data, virt_addr     valid & ready
// rsp       out  xlat_addr, mapped, large_page              valid & ready
// cfg       in   data (root_table_base)                     valid & ready, ready tied high
//
// Write item: stored at the accept edge, result valid the next cycle.
// Translate item: one cycle per table level read through the store's single
// read port, so the result is registered after the last level read (fault at level
// 4 soonest, 4 KiB mapping latest). req.ready is low while a walk is running.
// A stalled rsp holds the walk at its final level until the slot frees.
// Sync active-high reset clears control and the root register; the table
// store is not cleared.
module four_level_page_table_walker import pwt_pkg::*; #(
  parameter int STORE_WORDS = 4096
) (
  input logic    clk,
  input logic    rst,
  pwt_req_if.sink   req,
  pwt_rsp_if.source rsp,
  pwt_cfg_if.sink   cfg
);

  pwt_cmd_t    cmd;
  pwt_status_t status;

  assign cfg.ready = 1'b1;

  pwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_kind   (req.kind),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .status    (status),
    .cmd       (cmd)
  );

  pwt_dp #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_data   (cfg.data),
    .word_index (req.word_index),
    .word_data  (req.word_data),
    .virt_addr  (req.virt_addr),
    .cmd        (cmd),
    .status     (status),
    .xlat_addr  (rsp.xlat_addr),
    .mapped     (rsp.mapped),
    .large_page (rsp.large_page)
  );

`ifndef ASSERT_OFF
  // a translate walk closes the request side in the cycle after its accept
  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_XLATE) |=> !req.ready)
    else $error("request accepted during a walk");

  // a write transaction answers with an unmapped result on the next cycle
  a_write_rsp: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_WRITE) |=> (rsp.valid && !rsp.mapped))
    else $error("write result missing or mapped");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.mapped) |-> (rsp.xlat_addr == '0 && !rsp.large_page))
    else $error("unmapped result carries an address");

  a_large_mapped: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.large_page) |-> rsp.mapped)
    else $error("large page flagged without mapping");
`endif

endmodule

/* tb/tb_four_level_page_table_walker.sv */
// Self-checking testbench for four_level_page_table_walker: table writes and
// translations against a shadow walk, with random idling on req and rsp.
// Depends on pwt_pkg and the channel interfaces in pwt_if.sv.
`timescale 1ns / 1ps

module tb_four_level_page_table_walker;
  import pwt_pkg::*;

  localparam int STORE_WORDS = 4096;

  typedef struct packed {
    logic              kind;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_data;
    logic [VA_W-1:0]   virt_addr;
  } walk_req_t;

  typedef struct packed {
    logic [PA_W-1:0] xlat_addr;
    logic            mapped;
    logic            large_page;
  } walk_rsp_t;

  class pwt_scoreboard;
    logic [WORD_W-1:0] table_words [STORE_WORDS];
    bit                word_valid [STORE_WORDS];
    logic [PA_W-1:0]   root_base;
    walk_rsp_t         expected_q [$];
    int                errors;

    function new();
      root_base = '0;
      errors = 0;
      foreach (word_valid[i]) word_valid[i] = 1'b0;
    endfunction

    function void set_root(logic [PA_W-1:0] base);
      root_base = base;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Walks the shadow tables. hole is the first never-written word the walk
    // would touch, or -1 when the walk stays on written words.
    function walk_rsp_t walk_va(input logic [VA_W-1:0] va, output int hole,
                                output pwt_lvl_t hole_lvl);
      logic [PA_W-1:0]   tbl;
      logic [WORD_W-1:0] ent;
      logic [WORD_W-1:0] waddr;
      pwt_lvl_t          lvl;
      int                w;
      walk_rsp_t         r;
      r = '0;
      hole = -1;
      hole_lvl = LVL_4;
      tbl = root_base;
      for (int step = 0; step < 4; step++) begin
        lvl = pwt_lvl_t'(step);
        waddr = ({12'h0, tbl[PA_W-1:12], 12'h0} >> 3) + va[39 - 9*step +: LIDX_W];
        w = int'(waddr % STORE_WORDS);
        if (!word_valid[w]) begin
          hole = w;
          hole_lvl = lvl;
          return r;
        end
        ent = table_words[w];
        if (lvl == LVL_2 && ent[HUGE_BIT]) begin
          r.xlat_addr = {ent[PA_W-1:21], va[20:0]};
          r.mapped = 1'b1;
          r.large_page = 1'b1;
          return r;
        end
        if (lvl == LVL_1) begin
          if (ent[PRESENT_BIT]) begin
            r.xlat_addr = {ent[PA_W-1:12], va[11:0]};
            r.mapped = 1'b1;
          end
          return r;
        end
        if (ent[PA_W-1:12] == '0) return r;
        tbl = ent[PA_W-1:0];
      end
      return r;
    endfunction

    function void note_request(walk_req_t it);
      walk_rsp_t r;
      int        hole;
      pwt_lvl_t  hole_lvl;
      int        w;
      if (it.kind == KIND_WRITE) begin
        w = int'(it.word_index) % STORE_WORDS;
        table_words[w] = it.word_data;
        word_valid[w] = 1'b1;
        r = '0;
      end else begin
        r = walk_va(it.virt_addr, hole, hole_lvl);
        if (hole >= 0) begin
          $error("walk of %h reads unwritten store word %0d", it.virt_addr, hole);
          errors++;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_response(walk_rsp_t got);
      walk_rsp_t want;
      if (expected_q.size() == 0) begin
        $error("response with nothing outstanding, xlat_addr %h", got.xlat_addr);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.xlat_addr !== want.xlat_addr) begin
        $error("xlat_addr: expected %h, actual %h", want.xlat_addr, got.xlat_addr);
        errors++;
      end
      if (got.mapped !== want.mapped) begin
        $error("mapped: expected %b, actual %b", want.mapped, got.mapped);
        errors++;
      end
      if (got.large_page !== want.large_page) begin
        $error("large_page: expected %b, actual %b", want.large_page, got.large_page);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  pwt_req_if req_ch ();
  pwt_rsp_if rsp_ch ();
  pwt_cfg_if cfg_ch ();

  four_level_page_table_walker #(
    .STORE_WORDS (STORE_WORDS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #6 clk = ~clk;

  pwt_scoreboard   sb = new();
  logic [VA_W-1:0] va_pool [$];
  bit              tx_free = 1'b0;
  bit              rx_free = 1'b0;
  int              n_sent;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic walk_req_t wr_item(logic [WIDX_W-1:0] idx, logic [WORD_W-1:0] data);
    walk_req_t  it;
    logic [63:0] r;
    r = rand64();
    it.kind = KIND_WRITE;
    it.word_index = idx;
    it.word_data = data;
    it.virt_addr = r[VA_W-1:0];
    return it;
  endfunction

  function automatic walk_req_t xl_item(logic [VA_W-1:0] va);
    walk_req_t it;
    it.kind = KIND_XLATE;
    it.word_index = WIDX_W'($urandom);
    it.word_data = rand64();
    it.virt_addr = va;
    return it;
  endfunction

  // Entry for a table word that a walk is about to touch; biased so most
  // walks go deep, with some faults and huge pages mixed in.
  function automatic logic [WORD_W-1:0] make_entry(pwt_lvl_t lvl);
    logic [63:0] e;
    logic [63:0] a;
    int          roll;
    e = rand64();
    a = rand64();
    if ($urandom_range(0, 19) == 0) a = '1;
    if (a[39:0] == '0) a[0] = 1'b1;
    e[PA_W-1:12] = a[39:0];
    roll = $urandom_range(0, 99);
    case (lvl)
      LVL_2: begin
        if (roll < 30) begin
          e[HUGE_BIT] = 1'b1;
        end else begin
          e[HUGE_BIT] = 1'b0;
          if (roll < 40) e[PA_W-1:12] = '0;
        end
      end
      LVL_1: e[PRESENT_BIT] = (roll >= 20);
      default: if (roll < 8) e[PA_W-1:12] = '0;
    endcase
    return e;
  endfunction

  // Reuses recent addresses with a field changed so walks share tables.
  function automatic logic [VA_W-1:0] next_va();
    logic [63:0]     r;
    logic [VA_W-1:0] va;
    r = rand64();
    if (va_pool.size() == 0 || $urandom_range(0, 9) < 4) begin
      va = r[VA_W-1:0];
    end else begin
      va = va_pool[$urandom_range(0, va_pool.size() - 1)];
      case ($urandom_range(0, 3))
        0: va[11:0] = r[11:0];
        1: va[20:12] = 9'($urandom_range(0, 3));
        2: va[29:21] = 9'($urandom_range(0, 3));
        default: va[38:0] = r[38:0];
      endcase
    end
    va_pool.push_back(va);
    if (va_pool.size() > 16) void'(va_pool.pop_front());
    return va;
  endfunction

  task automatic send_item(walk_req_t it);
    int gap;
    gap = tx_free ? 0 : pick_gap();
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= it.kind;
    req_ch.word_index <= it.word_index;
    req_ch.word_data  <= it.word_data;
    req_ch.virt_addr  <= it.virt_addr;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(it);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_root(logic [PA_W-1:0] base);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= base;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_root(base);
    cfg_ch.valid <= 1'b0;
  endtask

  // Fills every never-written word on the walk first, then translates.
  task automatic translate(logic [VA_W-1:0] va);
    int        hole;
    pwt_lvl_t  hole_lvl;
    void'(sb.walk_va(va, hole, hole_lvl));
    while (hole >= 0) begin
      send_item(wr_item(WIDX_W'(hole), make_entry(hole_lvl)));
      n_sent++;
      void'(sb.walk_va(va, hole, hole_lvl));
    end
    send_item(xl_item(va));
    n_sent++;
  endtask

  // Root 0: level-4 table in words 0..511, then tables at 0x1000, 0x2000, 0x3000.
  task automatic directed_walks();
    send_item(wr_item(12'd0, 64'hFFF0_0000_0000_1000));    // upper bits ignored
    send_item(wr_item(12'd512, 64'h8000_0000_0000_2000));
    send_item(wr_item(12'd1024, 64'h0000_0000_0000_3000));
    send_item(wr_item(12'd1536, 64'h0000_0000_0000_4001));
    send_item(xl_item(48'h0));                              // 4 KiB page
    send_item(wr_item(12'd1025, 64'h000F_FFFF_FFFF_FF80));  // huge, bits 20:12 set
    send_item(xl_item(48'h3F_FFFF));
    send_item(wr_item(12'd1537, 64'h0));
    send_item(xl_item(48'h1ABC));                           // not present
    send_item(wr_item(12'd1026, 64'hFFF0_0000_0000_0F7F));
    send_item(xl_item(48'h40_0000));                        // level-2 fault
    send_item(wr_item(12'd513, 64'hFFF0_0000_0000_0FFF));
    send_item(xl_item(48'h4000_0000));                      // level-3 fault
    send_item(wr_item(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(wr_item(12'd511, 64'h0000_0000_0000_7000));
    send_item(xl_item(48'hFFFF_FFFF_FFFF));                 // all-ones huge mapping
    send_item(wr_item(12'd1, 64'h0));
    send_item(xl_item(48'h80_0000_0000));                   // level-4 fault
  endtask

  task automatic run_phase(logic [PA_W-1:0] base, int n_items, bit no_idle);
    bit paused;
    logic [63:0] r;
    paused = 1'b0;
    drain_results();
    write_root(base);
    tx_free = no_idle;
    rx_free = no_idle;
    n_sent = 0;
    while (n_sent < n_items) begin
      if (!paused && n_sent >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        r = rand64();
        send_item(wr_item(r[WIDX_W-1:0], rand64()));
        n_sent++;
      end else begin
        translate(next_va());
      end
    end
  endtask

  // response side: random stalls unless rx_free
  initial begin
    int stall;
    bit rdy;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall == 0 && !rx_free && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
      rdy = (stall == 0);
      if (stall > 0) stall--;
      rsp_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      sb.check_response('{rsp_ch.xlat_addr, rsp_ch.mapped, rsp_ch.large_page});
    end
  end

  initial begin
    logic [63:0] r;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_WRITE;
    req_ch.word_index = '0;
    req_ch.word_data  = '0;
    req_ch.virt_addr  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_root('0);
    directed_walks();

    run_phase('0, 140, 1'b0);
    run_phase({PA_W{1'b1}}, 140, 1'b1);
    r = rand64();
    run_phase(r[PA_W-1:0], 140, 1'b0);
    run_phase(52'h0_0000_0000_0FFF, 140, 1'b0);   // offset bits of the root are ignored
    r = rand64();
    run_phase(r[PA_W-1:0], 140, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_four_level_page_table_walker: clean");
    end else begin
      $display("tb_four_level_page_table_walker: errors");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb_four_level_page_table_walker: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/pwt_pkg.sv
rtl/pwt_if.sv
rtl/pwt_ctrl.sv
rtl/pwt_dp.sv
rtl/four_level_page_table_walker.sv
tb/tb_four_level_page_table_walker.sv
